FILE: src/software_timer_bank_assert.svh
// Assertion macros shared by the timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define SWTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define SWTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define SWTB_ASSERT_NOW(label, clk, rst, ante, cons)
`define SWTB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/swtb_pkg.sv
// Types and constants for the software timer bank.
`default_nettype none

package swtb_pkg;

   localparam int KIND_BITS = 3;
   localparam int ID_BITS   = 8;

   localparam logic [KIND_BITS-1:0] KIND_REGISTER = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_PERIOD   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_START    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_STOP     = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR    = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_TICK     = 3'd5;

   // Results reported per tick.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   // Request broadcast to every cell.
   typedef struct packed {
      logic                 go;
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   id;
      logic                 single;
      logic                 dup;
   } cmd_type;

   // What a cell shows to the control logic and to its neighbors.
   typedef struct packed {
      logic               used;
      logic               match;
      logic               pend;
      logic [ID_BITS-1:0] pend_id;
   } cell_status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

`default_nettype wire

FILE: src/swtb_cell.sv
// One timer slot: id, period, count, flags, and one stage of the expiry shift chain.
`default_nettype none

module swtb_cell #(
   parameter int PERIOD_BITS = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  swtb_pkg::cmd_type         cmd,
   input  wire  [PERIOD_BITS-1:0]    period,
   input  wire                       prev_used,
   input  wire                       shift,
   input  swtb_pkg::cell_status_type nxt,
   output swtb_pkg::cell_status_type status
);

   logic                         used_ff,    used_in;
   logic                         running_ff, running_in;
   logic                         single_ff,  single_in;
   logic [swtb_pkg::ID_BITS-1:0] id_ff,      id_in;
   logic [PERIOD_BITS-1:0]       period_ff,  period_in;
   logic [PERIOD_BITS-1:0]       count_ff,   count_in;
   logic                         pend_ff,    pend_in;
   logic [swtb_pkg::ID_BITS-1:0] pend_id_ff, pend_id_in;

   logic                   match;
   logic                   target;
   logic [PERIOD_BITS-1:0] count_inc;

   assign match     = used_ff && (id_ff == cmd.id);
   // first free slot: previous one is taken, this one is not
   assign target    = prev_used && !used_ff;
   assign count_inc = count_ff + PERIOD_BITS'(1);

   always_comb begin
      used_in    = used_ff;
      running_in = running_ff;
      single_in  = single_ff;
      id_in      = id_ff;
      period_in  = period_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      pend_id_in = pend_id_ff;
      if (shift) begin
         pend_in    = nxt.pend;
         pend_id_in = nxt.pend_id;
      end
      if (cmd.go) begin
         case (cmd.kind)
            swtb_pkg::KIND_REGISTER: begin
               if (target && !cmd.dup) begin
                  used_in    = 1'b1;
                  id_in      = cmd.id;
                  period_in  = period;
                  count_in   = '0;
                  running_in = 1'b0;
                  single_in  = cmd.single;
               end
            end
            swtb_pkg::KIND_PERIOD: begin
               if (match) period_in = period;
            end
            swtb_pkg::KIND_START: begin
               if (match) running_in = 1'b1;
            end
            swtb_pkg::KIND_STOP: begin
               if (match) running_in = 1'b0;
            end
            swtb_pkg::KIND_CLEAR: begin
               if (match) count_in = '0;
            end
            swtb_pkg::KIND_TICK: begin
               pend_in = 1'b0;
               if (used_ff && running_ff) begin
                  if (count_inc >= period_ff) begin
                     count_in   = '0;
                     pend_in    = 1'b1;
                     pend_id_in = id_ff;
                     if (single_ff) running_in = 1'b0;
                  end else begin
                     count_in = count_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= 1'b0;
         running_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         used_ff    <= used_in;
         running_ff <= running_in;
         pend_ff    <= pend_in;
      end
      single_ff  <= single_in;
      id_ff      <= id_in;
      period_ff  <= period_in;
      count_ff   <= count_in;
      pend_id_ff <= pend_id_in;
   end

   assign status.used    = used_ff;
   assign status.match   = match;
   assign status.pend    = pend_ff;
   assign status.pend_id = pend_id_ff;

endmodule

`default_nettype wire

FILE: src/software_timer_bank.sv
// Top level of the software timer bank: a row of timer cells and the expiry readout.
`default_nettype none
`include "software_timer_bank_assert.svh"

// A bank of NUM_SLOTS timers held in a row of cells, one slot per cell. Every request
// goes to all cells and they act on it together. A tick marks each expired timer in
// its cell; the marks then shift one cell a cycle toward slot 0, unless rsp_stall holds
// back a result while slot 0 has a mark, and the output register picks them up in
// registration order, so a tick holds off the next request until all marks have drained.
// At most 16 results are reported per tick; the last one carries rsp_last_in_run.
// Other requests do not hold off the next one.
module software_timer_bank #(
   parameter int NUM_SLOTS   = 16,
   parameter int PERIOD_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_kind,
   input  wire  [7:0]  req_timer_id,
   input  wire  [31:0] req_period_value,
   input  wire         req_one_shot,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_last_in_run
);

   swtb_pkg::state_type state_ff, state_in;
   logic [swtb_pkg::CNT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_id_ff,    rsp_id_in;
   logic       rsp_last_ff,  rsp_last_in;

   swtb_pkg::cmd_type         cmd;
   swtb_pkg::cell_status_type stat [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]      used_vec, match_vec, pend_vec;
   logic                      accept, shift, can_load, load, pend_rest;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != swtb_pkg::ST_IDLE);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         used_vec[i]  = stat[i].used;
         match_vec[i] = stat[i].match;
         pend_vec[i]  = stat[i].pend;
      end
   end

   assign cmd.go     = accept;
   assign cmd.kind   = req_kind;
   assign cmd.id     = req_timer_id;
   assign cmd.single = req_one_shot;
   assign cmd.dup    = |match_vec;

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
         logic                      prev_used;
         swtb_pkg::cell_status_type nxt;
         if (g == 0) begin : g_first
            assign prev_used = 1'b1;
         end else begin : g_link
            assign prev_used = stat[g-1].used;
         end
         if (g == NUM_SLOTS - 1) begin : g_end
            assign nxt = '0;
         end else begin : g_next
            assign nxt = stat[g+1];
         end
         swtb_cell #(
            .PERIOD_BITS(PERIOD_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .period    (req_period_value[PERIOD_BITS-1:0]),
            .prev_used (prev_used),
            .shift     (shift),
            .nxt       (nxt),
            .status    (stat[g])
         );
      end
   endgenerate

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign pend_rest = (pend_vec >> 1) != '0;
   // slot 0 holds the next expiry; over the limit it is dropped without a result
   assign load  = (state_ff == swtb_pkg::ST_DRAIN) && pend_vec[0] &&
                  (out_cnt_ff < swtb_pkg::CNT_BITS'(swtb_pkg::MAX_RESULTS)) && can_load;
   assign shift = (state_ff == swtb_pkg::ST_DRAIN) &&
                  (!pend_vec[0] || load ||
                   (out_cnt_ff >= swtb_pkg::CNT_BITS'(swtb_pkg::MAX_RESULTS)));

   always_comb begin
      state_in     = state_ff;
      out_cnt_in   = out_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         swtb_pkg::ST_IDLE: begin
            if (accept && (req_kind == swtb_pkg::KIND_TICK)) begin
               state_in   = swtb_pkg::ST_DRAIN;
               out_cnt_in = '0;
            end
         end
         swtb_pkg::ST_DRAIN: begin
            if (pend_vec == '0) begin
               state_in = swtb_pkg::ST_IDLE;
            end else if (load) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = stat[0].pend_id;
               rsp_last_in  = !pend_rest ||
                  (out_cnt_ff == swtb_pkg::CNT_BITS'(swtb_pkg::MAX_RESULTS - 1));
               out_cnt_in   = out_cnt_ff + swtb_pkg::CNT_BITS'(1);
            end
         end
         default: begin
            state_in = swtb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtb_pkg::ST_IDLE;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_id    = rsp_id_ff;
   assign rsp_last_in_run = rsp_last_ff;

   `SWTB_ASSERT_NOW(a_cnt_limit, clock, reset, 1'b1,
      out_cnt_ff <= swtb_pkg::CNT_BITS'(swtb_pkg::MAX_RESULTS))
   `SWTB_ASSERT_NOW(a_used_packed, clock, reset, 1'b1,
      ((used_vec >> 1) & ~used_vec) == '0)
   `SWTB_ASSERT_NEXT(a_used_sticky, clock, reset, 1'b1,
      ($past(used_vec) & ~used_vec) == '0)
   `SWTB_ASSERT_NOW(a_pend_idle, clock, reset, state_ff == swtb_pkg::ST_IDLE,
      pend_vec == '0)
   `SWTB_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for software_timer_bank: timer commands checked against a local timer model.
module tb;

   localparam int NUM_TIMERS   = 16;
   localparam int RANDOM_MIX   = 86;
   localparam int CALM_TAIL    = 25;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 40;
   localparam int STUCK_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;

   // Kinds the block ignores.
   localparam logic [swtb_pkg::KIND_BITS-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [swtb_pkg::KIND_BITS-1:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [swtb_pkg::KIND_BITS-1:0] kind;
      logic [7:0]                     id;
      logic [31:0]                    period;
      logic                           one_shot;
   } timer_cmd_type;

   typedef struct packed {
      logic [7:0] id;
      logic       last;
   } expiry_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind         = '0;
   logic [7:0]  req_timer_id     = '0;
   logic [31:0] req_period_value = '0;
   logic        req_one_shot     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_fired_id;
   logic        rsp_last_in_run;

   software_timer_bank dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_timer_id     (req_timer_id),
      .req_period_value (req_period_value),
      .req_one_shot     (req_one_shot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fired_id     (rsp_fired_id),
      .rsp_last_in_run  (rsp_last_in_run)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the timer table.
   logic [7:0]  bank_id     [NUM_TIMERS];
   logic [31:0] bank_period [NUM_TIMERS];
   logic [31:0] bank_count  [NUM_TIMERS];
   logic        bank_run    [NUM_TIMERS];
   logic        bank_single [NUM_TIMERS];
   int          bank_fill = 0;

   timer_cmd_type pending_cmds[$];
   expiry_type    expiry_q[$];
   logic [7:0]    known_ids[$];

   timer_cmd_type cur_cmd;
   expiry_type    want;
   int          total_items   = 0;
   int          reqs_accepted = 0;
   int          hold_at       = 0;
   bit          hold_done     = 1'b0;
   int          gap_left      = 0;
   int          stall_left    = 0;
   int          stuck_cycles  = 0;
   int          mismatches    = 0;

   function automatic int find_timer(logic [7:0] id);
      for (int i = 0; i < bank_fill; i++)
         if (bank_id[i] == id) return i;
      return -1;
   endfunction

   // Update the timer table for one request and queue the expiries it causes.
   function automatic void apply_timer_cmd(timer_cmd_type c);
      logic [7:0] hits [swtb_pkg::MAX_RESULTS];
      int         n;
      int         slot;
      n = 0;
      if (c.kind == swtb_pkg::KIND_TICK) begin
         for (int i = 0; i < bank_fill; i++) begin
            if (bank_run[i]) begin
               bank_count[i] = bank_count[i] + 32'd1;
               if (bank_count[i] >= bank_period[i]) begin
                  bank_count[i] = '0;
                  if (n < swtb_pkg::MAX_RESULTS) begin
                     hits[n] = bank_id[i];
                     n++;
                  end
                  if (bank_single[i]) bank_run[i] = 1'b0;
               end
            end
         end
         for (int k = 0; k < n; k++)
            expiry_q.push_back({hits[k], k == n - 1});
      end else if (c.kind == swtb_pkg::KIND_REGISTER) begin
         if (find_timer(c.id) < 0 && bank_fill < NUM_TIMERS) begin
            bank_id[bank_fill]     = c.id;
            bank_period[bank_fill] = c.period;
            bank_count[bank_fill]  = '0;
            bank_run[bank_fill]    = 1'b0;
            bank_single[bank_fill] = c.one_shot;
            bank_fill++;
         end
      end else begin
         slot = find_timer(c.id);
         if (slot >= 0) begin
            case (c.kind)
               swtb_pkg::KIND_PERIOD: bank_period[slot] = c.period;
               swtb_pkg::KIND_START:  bank_run[slot]    = 1'b1;
               swtb_pkg::KIND_STOP:   bank_run[slot]    = 1'b0;
               swtb_pkg::KIND_CLEAR:  bank_count[slot]  = '0;
               default: ;
            endcase
         end
      end
   endfunction

   function automatic bit quiet_phase();
      return (reqs_accepted + CALM_TAIL >= total_items) || (reqs_accepted % 48 >= 34);
   endfunction

   // Stimulus building
   function automatic void add_cmd(logic [2:0] k, logic [7:0] id, logic [31:0] p, logic s);
      pending_cmds.push_back({k, id, p, s});
   endfunction

   function automatic void add_tick();
      add_cmd(swtb_pkg::KIND_TICK, 8'($urandom_range(0, 255)), $urandom(),
              1'($urandom_range(0, 1)));
   endfunction

   function automatic bit is_known(logic [7:0] id);
      foreach (known_ids[i])
         if (known_ids[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void add_register(logic [7:0] id, logic [31:0] p, logic s);
      add_cmd(swtb_pkg::KIND_REGISTER, id, p, s);
      if (!is_known(id) && known_ids.size() < NUM_TIMERS) known_ids.push_back(id);
   endfunction

   function automatic logic [7:0] pick_id();
      if (known_ids.size() == 0 || $urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_period();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return 32'($urandom_range(0, 6));
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_timer_cmd(cur_cmd);
            reqs_accepted <= reqs_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               cur_cmd          = pending_cmds.pop_front();
               req_kind         <= cur_cmd.kind;
               req_timer_id     <= cur_cmd.id;
               req_period_value <= cur_cmd.period;
               req_one_shot     <= cur_cmd.one_shot;
               req_valid        <= 1'b1;
               if (!quiet_phase() && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side stall: random bursts, plus one long hold right after the all-expire tick
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && hold_at > 0 && reqs_accepted >= hold_at) begin
            stall_left = LONG_HOLD;
            hold_done  = 1'b1;
         end else if (stall_left == 0 && !quiet_phase() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expiry_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: unexpected expiry id %02h last %0d",
                        rsp_fired_id, rsp_last_in_run);
         end else begin
            want = expiry_q.pop_front();
            if (rsp_fired_id !== want.id || rsp_last_in_run !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: expiry expected id %02h last %0d, got id %02h last %0d",
                           want.id, want.last, rsp_fired_id, rsp_last_in_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int         roll;
      logic [7:0] id;

      // Directed: commands before any timer exists, ignored kinds
      add_cmd(swtb_pkg::KIND_START, 8'h11, 32'd0, 1'b0);
      add_cmd(swtb_pkg::KIND_CLEAR, 8'h11, 32'd5, 1'b1);
      add_tick();
      add_cmd(KIND_SPARE6, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      add_cmd(KIND_SPARE7, 8'h00, 32'd0, 1'b0);
      // period zero, widest period one-shot, duplicate id
      add_register(8'h00, 32'd0, 1'b0);
      add_register(8'hFF, 32'hFFFF_FFFF, 1'b1);
      add_register(8'h00, 32'd1, 1'b1);
      add_cmd(swtb_pkg::KIND_START, 8'h00, 32'd0, 1'b0);
      add_cmd(swtb_pkg::KIND_START, 8'hFF, 32'd0, 1'b0);
      add_tick();
      add_register(8'hA5, 32'd2, 1'b1);
      add_cmd(swtb_pkg::KIND_START, 8'hA5, 32'd0, 1'b0);
      add_tick();
      add_tick();
      add_tick();
      // period dropped below the count: fires on the next tick
      add_cmd(swtb_pkg::KIND_PERIOD, 8'hFF, 32'd2, 1'b0);
      add_cmd(swtb_pkg::KIND_STOP, 8'h00, 32'd0, 1'b0);
      // unknown ids
      add_cmd(swtb_pkg::KIND_CLEAR, 8'h42, 32'd0, 1'b0);
      add_cmd(swtb_pkg::KIND_PERIOD, 8'h42, 32'd0, 1'b1);
      add_tick();
      add_cmd(swtb_pkg::KIND_START, 8'hFF, 32'd0, 1'b0);
      add_cmd(swtb_pkg::KIND_CLEAR, 8'hFF, 32'd0, 1'b0);
      add_tick();
      add_tick();

      // Fill the bank with starts and ticks in between
      while (known_ids.size() < NUM_TIMERS) begin
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            id = (roll == 0) ? pick_id() : 8'($urandom_range(0, 255));
            add_register(id, pick_period(), 1'($urandom_range(0, 1)));
         end else if (roll < 8) begin
            add_cmd(swtb_pkg::KIND_START, pick_id(), $urandom(), 1'($urandom_range(0, 1)));
         end else begin
            add_tick();
         end
      end
      // bank full: this one is dropped
      do id = 8'($urandom_range(0, 255)); while (is_known(id));
      add_cmd(swtb_pkg::KIND_REGISTER, id, 32'd0, 1'b0);

      // All timers expire on one tick while the result side holds off
      foreach (known_ids[i]) begin
         add_cmd(swtb_pkg::KIND_PERIOD, known_ids[i], 32'd0, 1'($urandom_range(0, 1)));
         add_cmd(swtb_pkg::KIND_START, known_ids[i], $urandom(), 1'($urandom_range(0, 1)));
      end
      hold_at = pending_cmds.size() + 1;
      add_tick();
      add_tick();
      add_tick();

      // Random mix of commands, mostly on registered ids
      repeat (RANDOM_MIX) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            add_tick();
         else if (roll < 50)
            add_cmd(swtb_pkg::KIND_PERIOD, pick_id(), pick_period(),
                    1'($urandom_range(0, 1)));
         else if (roll < 62)
            add_cmd(swtb_pkg::KIND_START, pick_id(), $urandom(), 1'($urandom_range(0, 1)));
         else if (roll < 72)
            add_cmd(swtb_pkg::KIND_STOP, pick_id(), $urandom(), 1'($urandom_range(0, 1)));
         else if (roll < 82)
            add_cmd(swtb_pkg::KIND_CLEAR, pick_id(), $urandom(), 1'($urandom_range(0, 1)));
         else if (roll < 90)
            add_register(pick_id(), pick_period(), 1'($urandom_range(0, 1)));
         else if (roll < 95)
            add_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom(),
                    1'($urandom_range(0, 1)));
         else
            add_cmd(roll[0] ? KIND_SPARE7 : KIND_SPARE6, 8'($urandom_range(0, 255)),
                    $urandom(), 1'($urandom_range(0, 1)));
      end
      total_items = pending_cmds.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (reqs_accepted < total_items || expiry_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
